// ===== design/pivw_pkg.sv =====
`default_nettype none

package pivw_pkg;

    // fixed result field widths
    localparam int WEIGHT_W = 48;
    localparam int STATUS_W = 2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ZERO_VAR = 2'd1;
    localparam logic [STATUS_W-1:0] ST_SINGLE   = 2'd2;

    // commands from controller to datapath
    typedef struct packed {
        logic load_in;   // latch the accepted word
        logic unit;      // unit-weight mode word: load 1.0 and clear pool
        logic accum;     // add latched sample into pool accumulators
        logic prep;      // start of pool close: load multiplier and numerator
        logic mul_step;  // one shift-add step of |sum|^2
        logic den;       // form denominator, clear remainder
        logic div_step;  // one restoring division step
        logic result;    // pick weight and status, load emit count
        logic pop;       // one result word taken
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic mode;       // weight_mode register
        logic pool_end;   // sample being accumulated closes the pool
        logic emit_last;  // word on the output is the last of its run
    } t_stat;

endpackage

`default_nettype wire

// ===== design/pivw_in_if.sv =====
`default_nettype none

interface pivw_in_if #(
    parameter int SAMPLE_BITS = 24
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          last_in_pool;

    modport source (output valid, output sample, output last_in_pool, input ready);
    modport sink   (input valid, input sample, input last_in_pool, output ready);
endinterface

`default_nettype wire

// ===== design/pivw_out_if.sv =====
`default_nettype none

interface pivw_out_if;
    logic                               valid;
    logic                               ready;
    logic [pivw_pkg::WEIGHT_W-1:0]      weight;
    logic [pivw_pkg::STATUS_W-1:0]      status;
    logic                               last_of_run;

    modport source (output valid, output weight, output status, output last_of_run,
                    input ready);
    modport sink   (input valid, input weight, input status, input last_of_run,
                    output ready);
endinterface

`default_nettype wire

// ===== design/pooled_inverse_variance_weights_core.sv =====
`default_nettype none

// Pooled inverse-variance weights. Signed samples stream in on i_in, the last
// sample of each pool marked; a pool also closes when it reaches MAX_POOL
// samples. With weight_mode 0 each pool close emits one word per pool sample,
// all carrying floor(2^WEIGHT_FRAC_BITS * n(n-1) / (n*sumsq - sum^2)), with
// last_of_run on the final one; a one-sample pool or a zero variance gives an
// all-ones weight with status 2 or 1. With weight_mode 1 every sample gives one
// word of weight 1.0 at once and any partial pool is dropped. Each sample is
// accepted, then accumulated into the pool. A pool close then runs the
// bit-serial square of the sum, forms the denominator, runs the restoring
// divider and picks the result before emitting the words. A unit-mode sample
// is accepted and emitted with no accumulation. One word is in flight at a
// time; i_in is not ready while results are pending. weight_mode is written
// through i_cfg_we / i_cfg_wdata; the user must write it only while the block
// idles, as the block itself does not enforce this.

module pooled_inverse_variance_weights_core #(
    parameter int SAMPLE_BITS      = 24,
    parameter int MAX_POOL         = 64,
    parameter int WEIGHT_FRAC_BITS = 32
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_cfg_we,
    input  wire          i_cfg_wdata,
    pivw_in_if.sink      i_in,
    pivw_out_if.source   o_out
);

    localparam int MUL_STEPS = SAMPLE_BITS + $clog2(MAX_POOL);
    localparam int DIV_STEPS = 2 * $clog2(MAX_POOL + 1) + WEIGHT_FRAC_BITS;

    pivw_pkg::t_cmd   w_cmd;
    pivw_pkg::t_stat  w_stat;
    logic             w_in_ready;
    logic             w_out_valid;

    // sequencer
    pivw_ctrl #(
        .MUL_STEPS (MUL_STEPS),
        .DIV_STEPS (DIV_STEPS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (w_in_ready),
        .o_out_valid (w_out_valid),
        .i_out_ready (o_out.ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    // accumulators, divider and result register
    pivw_dp #(
        .SAMPLE_BITS      (SAMPLE_BITS),
        .MAX_POOL         (MAX_POOL),
        .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_sample       (i_in.sample),
        .i_last_in_pool (i_in.last_in_pool),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .o_weight       (o_out.weight),
        .o_status       (o_out.status),
        .o_last_of_run  (o_out.last_of_run)
    );

    assign i_in.ready  = w_in_ready;
    assign o_out.valid = w_out_valid;

    // input and output never open together: one word in flight
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_in_ready && w_out_valid))
        else $error("input ready while a result is pending");

    // the last word of a run closes the output
    a_run_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && o_out.last_of_run) |=> !o_out.valid)
        else $error("output still valid after last_of_run");

    // unit mode answers the next cycle with status ok
    a_unit_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_stat.mode && i_in.valid && w_in_ready)
        |=> (o_out.valid && o_out.status == pivw_pkg::ST_OK))
        else $error("unit-mode sample did not produce a word");

    // a saturated status always carries an all-ones weight
    a_sat_weight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.status != pivw_pkg::ST_OK) |-> (&o_out.weight))
        else $error("saturated status without all-ones weight");

endmodule

`default_nettype wire

// ===== design/pivw_ctrl.sv =====
`default_nettype none

module pivw_ctrl #(
    parameter int MUL_STEPS = 30,
    parameter int DIV_STEPS = 46
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  wire               i_out_ready,
    input  wire pivw_pkg::t_stat i_stat,
    output pivw_pkg::t_cmd    o_cmd
);

    localparam int MAX_STEPS = (MUL_STEPS > DIV_STEPS) ? MUL_STEPS : DIV_STEPS;
    localparam int STEP_W    = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_UPD  = 8'b0000_0010,
        S_PREP = 8'b0000_0100,
        S_MUL  = 8'b0000_1000,
        S_DEN  = 8'b0001_0000,
        S_DIV  = 8'b0010_0000,
        S_RES  = 8'b0100_0000,
        S_EMIT = 8'b1000_0000
    } t_state;

    t_state              r_state, n_state;
    logic [STEP_W-1:0]   r_step, n_step;

    // next state, commands and handshakes
    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    if (i_stat.mode) begin
                        o_cmd.unit = 1'b1;
                        n_state    = S_EMIT;
                    end else begin
                        n_state = S_UPD;
                    end
                end
            end
            S_UPD: begin
                o_cmd.accum = 1'b1;
                n_state     = i_stat.pool_end ? S_PREP : S_IDLE;
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_step     = STEP_W'(MUL_STEPS - 1);
                n_state    = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul_step = 1'b1;
                n_step         = r_step - STEP_W'(1);
                if (r_step == '0) n_state = S_DEN;
            end
            S_DEN: begin
                o_cmd.den = 1'b1;
                n_step    = STEP_W'(DIV_STEPS - 1);
                n_state   = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_step         = r_step - STEP_W'(1);
                if (r_step == '0) n_state = S_RES;
            end
            S_RES: begin
                o_cmd.result = 1'b1;
                n_state      = S_EMIT;
            end
            S_EMIT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    o_cmd.pop = 1'b1;
                    if (i_stat.emit_last) n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

endmodule

`default_nettype wire

// ===== design/pivw_dp.sv =====
`default_nettype none

module pivw_dp #(
    parameter int SAMPLE_BITS      = 24,
    parameter int MAX_POOL         = 64,
    parameter int WEIGHT_FRAC_BITS = 32
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_cfg_we,
    input  wire                               i_cfg_wdata,
    input  wire signed [SAMPLE_BITS-1:0]      i_sample,
    input  wire                               i_last_in_pool,
    input  wire pivw_pkg::t_cmd               i_cmd,
    output pivw_pkg::t_stat                   o_stat,
    output logic [pivw_pkg::WEIGHT_W-1:0]     o_weight,
    output logic [pivw_pkg::STATUS_W-1:0]     o_status,
    output logic                              o_last_of_run
);

    localparam int SB    = SAMPLE_BITS;
    localparam int CNT_W = $clog2(MAX_POOL + 1);
    localparam int LOG_P = $clog2(MAX_POOL);
    localparam int SUM_W = SB + LOG_P;          // signed pool sum
    localparam int SQ_W  = 2 * SB;              // one squared magnitude
    localparam int SS_W  = 2 * SB - 1 + LOG_P;  // pool sum of squares
    localparam int DEN_W = SS_W + CNT_W;        // n*sumsq and denominator
    localparam int NUM_W = 2 * CNT_W + WEIGHT_FRAC_BITS;
    localparam int WW    = pivw_pkg::WEIGHT_W;

    // config and input word
    logic                     r_mode;
    logic signed [SB-1:0]     r_smp;
    logic                     r_last;

    // pool accumulators
    logic [CNT_W-1:0]         r_cnt;
    logic signed [SUM_W-1:0]  r_sum;
    logic [SS_W-1:0]          r_ssq;

    // pool close arithmetic
    logic [SUM_W-1:0]         r_mplr;
    logic [DEN_W-1:0]         r_mcand;
    logic [DEN_W-1:0]         r_sq;
    logic [DEN_W-1:0]         r_nsq;
    logic [DEN_W-1:0]         r_den;
    logic [DEN_W-1:0]         r_rem;
    logic [NUM_W-1:0]         r_num;

    // result word
    logic [WW-1:0]            r_weight;
    logic [pivw_pkg::STATUS_W-1:0] r_status;
    logic [CNT_W-1:0]         r_left;
    logic                     r_unit;

    logic [SB-1:0]            w_mag;
    logic [SQ_W-1:0]          w_mag_sq;
    logic [CNT_W-1:0]         w_cnt_inc;
    logic [SUM_W-1:0]         w_abs;
    logic [DEN_W-1:0]         w_nsq;
    logic [2*CNT_W-1:0]       w_nn;
    logic [DEN_W:0]           w_trial;
    logic [DEN_W:0]           w_diff;
    logic                     w_ge;

    // sample magnitude and its square
    assign w_mag     = r_smp[SB-1] ? (~r_smp + SB'(1)) : r_smp;
    assign w_mag_sq  = w_mag * w_mag;
    assign w_cnt_inc = r_cnt + CNT_W'(1);

    // pool close operands
    assign w_abs = r_sum[SUM_W-1] ? (~r_sum + SUM_W'(1)) : r_sum;
    assign w_nsq = r_cnt * r_ssq;
    assign w_nn  = r_cnt * (r_cnt - CNT_W'(1));

    // restoring divider step
    assign w_trial = {r_rem, r_num[NUM_W-1]};
    assign w_diff  = w_trial - {1'b0, r_den};
    assign w_ge    = (w_trial >= {1'b0, r_den});

    assign o_stat.mode      = r_mode;
    assign o_stat.pool_end  = r_last || (w_cnt_inc == CNT_W'(MAX_POOL));
    assign o_stat.emit_last = (r_left == CNT_W'(1));

    assign o_weight      = r_weight;
    assign o_status      = r_status;
    assign o_last_of_run = r_unit ? r_last : (r_left == CNT_W'(1));

    // config register and pool accumulators
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
            r_cnt  <= '0;
            r_sum  <= '0;
            r_ssq  <= '0;
        end else begin
            if (i_cfg_we) r_mode <= i_cfg_wdata;
            if (i_cmd.unit || i_cmd.result) begin
                r_cnt <= '0;
                r_sum <= '0;
                r_ssq <= '0;
            end else if (i_cmd.accum) begin
                r_cnt <= w_cnt_inc;
                r_sum <= r_sum + SUM_W'(r_smp);
                r_ssq <= r_ssq + SS_W'(w_mag_sq);
            end
        end
    end

    // input word latch
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_smp  <= i_sample;
            r_last <= i_last_in_pool;
        end
    end

    // serial square of |sum|, denominator and divider
    always_ff @(posedge i_clk) begin
        if (i_cmd.prep) begin
            r_mplr  <= w_abs;
            r_mcand <= DEN_W'(w_abs);
            r_sq    <= '0;
            r_nsq   <= w_nsq;
            r_num   <= {w_nn, {WEIGHT_FRAC_BITS{1'b0}}};
        end
        if (i_cmd.mul_step) begin
            if (r_mplr[0]) r_sq <= r_sq + r_mcand;
            r_mplr  <= r_mplr >> 1;
            r_mcand <= r_mcand << 1;
        end
        if (i_cmd.den) begin
            r_den <= r_nsq - r_sq;
            r_rem <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem <= w_ge ? w_diff[DEN_W-1:0] : w_trial[DEN_W-1:0];
            r_num <= {r_num[NUM_W-2:0], w_ge};
        end
    end

    // result word and emit count
    always_ff @(posedge i_clk) begin
        if (i_cmd.unit) begin
            r_weight <= WW'(1) << WEIGHT_FRAC_BITS;
            r_status <= pivw_pkg::ST_OK;
            r_left   <= CNT_W'(1);
            r_unit   <= 1'b1;
        end else if (i_cmd.result) begin
            r_left <= r_cnt;
            r_unit <= 1'b0;
            if (r_cnt < CNT_W'(2)) begin
                r_weight <= '1;
                r_status <= pivw_pkg::ST_SINGLE;
            end else if (r_den == '0) begin
                r_weight <= '1;
                r_status <= pivw_pkg::ST_ZERO_VAR;
            end else begin
                r_weight <= WW'(r_num);
                r_status <= pivw_pkg::ST_OK;
            end
        end else if (i_cmd.pop) begin
            r_left <= r_left - CNT_W'(1);
        end
    end

endmodule

`default_nettype wire
